// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Types and constants shared by the alpha-over compositor modules.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned POS_W   = 13;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned WGT_W   = 2 * CH_W;
    localparam int unsigned NUM_W   = CH_W + WGT_W;
    localparam int unsigned REM_W   = NUM_W + 1;
    localparam int unsigned DVS_W   = WGT_W + 1;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [POS_W-1:0]        width;
        logic [POS_W-1:0]        height;
    } t_win;

    typedef struct packed {
        logic            in_win;
        logic            zero;
        logic [CH_W-1:0] base_red;
        logic [CH_W-1:0] base_green;
        logic [CH_W-1:0] base_blue;
        logic [CH_W-1:0] base_alpha;
        logic [CH_W-1:0] alpha;
    } t_side;

    typedef struct packed {
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]  quo;
        logic [DVS_W-1:0]             dvs;
        t_side                        side;
    } t_div;

endpackage

// File: sv/aoc_regs.sv
// ----------------------------------------------------------------------------
// aoc_regs
// APB register bank for the overlay window; width and height saturate.
// ----------------------------------------------------------------------------
module aoc_regs #(
    parameter int unsigned MAX_WIDTH  = aoc_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = aoc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aoc_pkg::APB_AW-1:0] paddr,
    input  logic [aoc_pkg::APB_DW-1:0] pwdata,
    output logic [aoc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output aoc_pkg::t_win              o_win
);

    localparam int unsigned POS_W = aoc_pkg::POS_W;
    localparam int unsigned CMP_W = POS_W + 2;

    aoc_pkg::t_win    r_win;
    aoc_pkg::t_win    n_win;
    aoc_pkg::t_reg_idx w_idx;
    logic             w_wr;
    logic [CMP_W-1:0] w_val;
    logic [POS_W-1:0] w_sat_w;
    logic [POS_W-1:0] w_sat_h;

    assign w_idx = aoc_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr  = psel & penable & pwrite;
    assign w_val = CMP_W'(pwdata[POS_W-1:0]);

    assign w_sat_w = (w_val > CMP_W'(MAX_WIDTH))  ? POS_W'(MAX_WIDTH)  : pwdata[POS_W-1:0];
    assign w_sat_h = (w_val > CMP_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) : pwdata[POS_W-1:0];

    always_comb begin
        n_win = r_win;
        if (w_wr) begin
            unique case (w_idx)
                aoc_pkg::REG_LEFT:   n_win.left   = $signed(pwdata[POS_W-1:0]);
                aoc_pkg::REG_TOP:    n_win.top    = $signed(pwdata[POS_W-1:0]);
                aoc_pkg::REG_WIDTH:  n_win.width  = w_sat_w;
                aoc_pkg::REG_HEIGHT: n_win.height = w_sat_h;
                default:             n_win = r_win;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    always_comb begin
        unique case (w_idx)
            aoc_pkg::REG_LEFT:   prdata = aoc_pkg::APB_DW'(r_win.left);
            aoc_pkg::REG_TOP:    prdata = aoc_pkg::APB_DW'(r_win.top);
            aoc_pkg::REG_WIDTH:  prdata = aoc_pkg::APB_DW'(r_win.width);
            aoc_pkg::REG_HEIGHT: prdata = aoc_pkg::APB_DW'(r_win.height);
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_win  = r_win;

endmodule

// File: sv/aoc_weight.sv
// ----------------------------------------------------------------------------
// aoc_weight
// First two pipeline stages: window test and alpha weights, then the blend
// numerators, rounding offset, divisor and output alpha.
// ----------------------------------------------------------------------------
module aoc_weight (
    input  logic                        i_clk,
    input  logic                        i_en1,
    input  logic                        i_en2,
    input  aoc_pkg::t_win               i_win,
    input  logic [aoc_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [aoc_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_red,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_green,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_blue,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_alpha,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_red,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_green,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_blue,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_alpha,
    output aoc_pkg::t_div               o_div
);

    localparam int unsigned CH_W   = aoc_pkg::CH_W;
    localparam int unsigned NUM_CH = aoc_pkg::NUM_CH;
    localparam int unsigned WGT_W  = aoc_pkg::WGT_W;
    localparam int unsigned NUM_W  = aoc_pkg::NUM_W;
    localparam int unsigned REM_W  = aoc_pkg::REM_W;
    localparam int unsigned POS_W  = aoc_pkg::POS_W;
    localparam int unsigned CRD_W  = aoc_pkg::COORD_W;
    localparam int unsigned SUM_W  = POS_W + 2;

    // Exact floor(x / 255) for x below 255 * 256.
    function automatic logic [CH_W-1:0] div255(input logic [WGT_W-1:0] x);
        logic [WGT_W:0] s;
        s = (WGT_W+1)'(x) + (WGT_W+1)'(1) + (WGT_W+1)'(x[WGT_W-1:CH_W]);
        return s[WGT_W-1:CH_W];
    endfunction

    // stage 1
    logic signed [SUM_W-1:0] w_px, w_py, w_left, w_top, w_right, w_bottom;
    logic                    w_inside;
    logic [CH_W-1:0]         w_inv_sa;
    logic [WGT_W-1:0]        w_w1, w_w2;
    logic [NUM_CH-1:0][CH_W-1:0] w_dc, w_sc;

    logic                        r_s1_inside;
    logic                        r_s1_zero;
    logic [WGT_W-1:0]            r_s1_w1;
    logic [WGT_W-1:0]            r_s1_w2;
    logic [CH_W-1:0]             r_s1_sa;
    logic [CH_W-1:0]             r_s1_da;
    logic [NUM_CH-1:0][CH_W-1:0] r_s1_dc;
    logic [NUM_CH-1:0][CH_W-1:0] r_s1_sc;

    // stage 2
    logic [WGT_W-1:0]             w_a;
    logic [NUM_CH-1:0][NUM_W-1:0] w_num;
    aoc_pkg::t_div                n_div;
    aoc_pkg::t_div                r_s2_div;

    assign w_px     = $signed({(SUM_W-CRD_W)'(0), i_pixel_x});
    assign w_py     = $signed({(SUM_W-CRD_W)'(0), i_pixel_y});
    assign w_left   = SUM_W'(i_win.left);
    assign w_top    = SUM_W'(i_win.top);
    assign w_right  = w_left + $signed({(SUM_W-POS_W)'(0), i_win.width});
    assign w_bottom = w_top + $signed({(SUM_W-POS_W)'(0), i_win.height});
    assign w_inside = (w_px >= w_left) && (w_px < w_right)
                   && (w_py >= w_top) && (w_py < w_bottom);

    assign w_inv_sa = {CH_W{1'b1}} - i_over_alpha;
    assign w_w1     = {i_over_alpha, CH_W'(0)} - WGT_W'(i_over_alpha);
    assign w_w2     = WGT_W'(i_base_alpha) * WGT_W'(w_inv_sa);
    assign w_dc     = {i_base_blue, i_base_green, i_base_red};
    assign w_sc     = {i_over_blue, i_over_green, i_over_red};

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_s1_inside <= w_inside;
            r_s1_zero   <= (i_over_alpha == '0) && (i_base_alpha == '0);
            r_s1_w1     <= w_w1;
            r_s1_w2     <= w_w2;
            r_s1_sa     <= i_over_alpha;
            r_s1_da     <= i_base_alpha;
            r_s1_dc     <= w_dc;
            r_s1_sc     <= w_sc;
        end
    end

    // Dividend is 2n + A and divisor 2A, so the quotient rounds half up.
    always_comb begin
        n_div = '0;
        w_a   = r_s1_w1 + r_s1_w2;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_num[ch] = NUM_W'(r_s1_sc[ch]) * NUM_W'(r_s1_w1)
                      + NUM_W'(r_s1_dc[ch]) * NUM_W'(r_s1_w2);
            n_div.rem[ch] = {w_num[ch], 1'b0} + REM_W'(w_a);
        end
        n_div.dvs             = {w_a, 1'b0};
        n_div.side.in_win     = r_s1_inside;
        n_div.side.zero       = r_s1_zero;
        n_div.side.base_red   = r_s1_dc[0];
        n_div.side.base_green = r_s1_dc[1];
        n_div.side.base_blue  = r_s1_dc[2];
        n_div.side.base_alpha = r_s1_da;
        n_div.side.alpha      = r_s1_sa + div255(r_s1_w2 + WGT_W'(127));
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s2_div <= n_div;
        end
    end

    assign o_div = r_s2_div;

endmodule

// File: sv/aoc_div_step.sv
// ----------------------------------------------------------------------------
// aoc_div_step
// One restoring-division stage: resolves quotient bit QBIT for all three
// color lanes and carries the side data along.
// ----------------------------------------------------------------------------
module aoc_div_step #(
    parameter int unsigned QBIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  aoc_pkg::t_div i_div,
    output aoc_pkg::t_div o_div
);

    localparam int unsigned NUM_CH = aoc_pkg::NUM_CH;
    localparam int unsigned REM_W  = aoc_pkg::REM_W;

    logic [REM_W-1:0] w_shift;
    aoc_pkg::t_div    n_div;
    aoc_pkg::t_div    r_div;

    assign w_shift = REM_W'(i_div.dvs) << QBIT;

    always_comb begin
        n_div = i_div;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (i_div.rem[ch] >= w_shift) begin
                n_div.rem[ch]       = i_div.rem[ch] - w_shift;
                n_div.quo[ch][QBIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// File: sv/alpha_over_compositor_unit.sv
// ----------------------------------------------------------------------------
// alpha_over_compositor_unit
// Porter-Duff over of a straight-alpha RGBA8 overlay onto a base pixel
// stream, limited to a programmable overlay window.
//
// Input channel: i_valid / o_stall carry one base pixel, its coordinates and
// the matching overlay pixel. Output channel: o_valid / i_stall carry the
// composited RGBA8 pixel, one result for every item, in order.
// The APB port sets the window (left, top, width, height at 0x0..0xC);
// write it only while no item is in flight.
// Pipeline from acceptance to o_valid: two stages for the window
// test and weights, eight for the per-channel divider (one quotient bit each),
// one output register. Throughput is one item per cycle while i_stall is low.
// Reset clears all stage valid bits and the window registers; an empty window
// passes every pixel through unchanged.
// When the receiver stalls, stages hold their items and bubbles close up;
// o_stall rises only when all eleven stages hold an item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alpha_over_compositor_unit #(
    parameter int unsigned MAX_WIDTH  = aoc_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = aoc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aoc_pkg::APB_AW-1:0]  paddr,
    input  logic [aoc_pkg::APB_DW-1:0]  pwdata,
    output logic [aoc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [aoc_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [aoc_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_red,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_green,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_blue,
    input  logic [aoc_pkg::CH_W-1:0]    i_base_alpha,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_red,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_green,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_blue,
    input  logic [aoc_pkg::CH_W-1:0]    i_over_alpha,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [aoc_pkg::CH_W-1:0]    o_out_red,
    output logic [aoc_pkg::CH_W-1:0]    o_out_green,
    output logic [aoc_pkg::CH_W-1:0]    o_out_blue,
    output logic [aoc_pkg::CH_W-1:0]    o_out_alpha
);

    localparam int unsigned CH_W   = aoc_pkg::CH_W;
    localparam int unsigned REM_W  = aoc_pkg::REM_W;
    localparam int unsigned N_DIV  = CH_W;
    localparam int unsigned N_STG  = 2 + N_DIV + 1;

    aoc_pkg::t_win   w_win;
    aoc_pkg::t_div   w_div [N_DIV+1];
    aoc_pkg::t_side  w_side;
    logic [N_STG:1]  w_en;
    logic [N_STG:1]  r_valid;
    logic [N_STG:1]  n_valid;

    logic [CH_W-1:0] r_out_red, r_out_green, r_out_blue, r_out_alpha;
    logic [CH_W-1:0] n_out_red, n_out_green, n_out_blue, n_out_alpha;

    aoc_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_win   (w_win)
    );

    // A stage loads when it is empty or its successor loads.
    assign w_en[N_STG] = ~r_valid[N_STG] | ~i_stall;
    for (genvar k = 1; k < N_STG; k++) begin : g_en
        assign w_en[k] = ~r_valid[k] | w_en[k+1];
    end

    always_comb begin
        n_valid = r_valid;
        if (w_en[1]) begin
            n_valid[1] = i_valid;
        end
        for (int k = 2; k <= N_STG; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    aoc_weight u_weight (
        .i_clk        (i_clk),
        .i_en1        (w_en[1]),
        .i_en2        (w_en[2]),
        .i_win        (w_win),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_base_red   (i_base_red),
        .i_base_green (i_base_green),
        .i_base_blue  (i_base_blue),
        .i_base_alpha (i_base_alpha),
        .i_over_red   (i_over_red),
        .i_over_green (i_over_green),
        .i_over_blue  (i_over_blue),
        .i_over_alpha (i_over_alpha),
        .o_div        (w_div[0])
    );

    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        aoc_div_step #(
            .QBIT (N_DIV - 1 - g)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_en[3+g]),
            .i_div (w_div[g]),
            .o_div (w_div[g+1])
        );
    end

    assign w_side = w_div[N_DIV].side;

    // Pass the base through outside the window; force zero when both alphas are.
    always_comb begin
        if (!w_side.in_win) begin
            n_out_red   = w_side.base_red;
            n_out_green = w_side.base_green;
            n_out_blue  = w_side.base_blue;
            n_out_alpha = w_side.base_alpha;
        end else if (w_side.zero) begin
            n_out_red   = '0;
            n_out_green = '0;
            n_out_blue  = '0;
            n_out_alpha = '0;
        end else begin
            n_out_red   = w_div[N_DIV].quo[0];
            n_out_green = w_div[N_DIV].quo[1];
            n_out_blue  = w_div[N_DIV].quo[2];
            n_out_alpha = w_side.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[N_STG]) begin
            r_out_red   <= n_out_red;
            r_out_green <= n_out_green;
            r_out_blue  <= n_out_blue;
            r_out_alpha <= n_out_alpha;
        end
    end

    assign o_stall     = ~w_en[1];
    assign o_valid     = r_valid[N_STG];
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

    `ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_valid == '1)
    `ASSERT_NXT(a_zero_alpha_clears, i_clk, i_rst_n, w_en[N_STG] && r_valid[N_STG-1] && w_side.in_win && w_side.zero, o_out_alpha == '0 && o_out_red == '0 && o_out_blue == '0)
    `ASSERT_IMP(a_div_rem_below_dvs, i_clk, i_rst_n, r_valid[N_STG-1] && w_side.in_win && !w_side.zero, w_div[N_DIV].rem[0] < REM_W'(w_div[N_DIV].dvs) && w_div[N_DIV].rem[1] < REM_W'(w_div[N_DIV].dvs) && w_div[N_DIV].rem[2] < REM_W'(w_div[N_DIV].dvs))

endmodule

// File: tb/tb_alpha_over_compositor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_over_compositor_unit
// Self-checking bench for the alpha-over compositor. A directed table covers
// the window edges, the empty and oversized windows and the alpha corners.
// Random phases then follow, each setting the window anew, with a repeating idle
// pattern. Every accepted pixel is predicted with exact integer math, and the
// composited result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_alpha_over_compositor_unit;

    localparam int PIPE_LAT    = 11;
    localparam int SETTLE      = PIPE_LAT + 4;
    localparam int QUIET_LIMIT = 5000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic [aoc_pkg::COORD_W-1:0] x;
        logic [aoc_pkg::COORD_W-1:0] y;
        logic [aoc_pkg::CH_W-1:0]    base_red;
        logic [aoc_pkg::CH_W-1:0]    base_green;
        logic [aoc_pkg::CH_W-1:0]    base_blue;
        logic [aoc_pkg::CH_W-1:0]    base_alpha;
        logic [aoc_pkg::CH_W-1:0]    over_red;
        logic [aoc_pkg::CH_W-1:0]    over_green;
        logic [aoc_pkg::CH_W-1:0]    over_blue;
        logic [aoc_pkg::CH_W-1:0]    over_alpha;
    } t_pix;

    typedef struct packed {
        logic [aoc_pkg::CH_W-1:0] red;
        logic [aoc_pkg::CH_W-1:0] green;
        logic [aoc_pkg::CH_W-1:0] blue;
        logic [aoc_pkg::CH_W-1:0] alpha;
    } t_rgba;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        aoc_pkg::t_reg_idx reg_idx;
        logic [31:0]       value;
        t_pix              pix;
        bit                typed;
        t_rgba             want;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [aoc_pkg::APB_AW-1:0]  paddr;
    logic [aoc_pkg::APB_DW-1:0]  pwdata;
    logic [aoc_pkg::APB_DW-1:0]  prdata;
    logic                        pready;
    logic                        i_valid;
    logic                        o_stall;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [aoc_pkg::CH_W-1:0]    o_out_red;
    logic [aoc_pkg::CH_W-1:0]    o_out_green;
    logic [aoc_pkg::CH_W-1:0]    o_out_blue;
    logic [aoc_pkg::CH_W-1:0]    o_out_alpha;

    t_pix  cur_pix;
    bit    pin_typed;
    t_rgba pin_want;

    // window shadow, decoded the way the block sees it
    int win_left;
    int win_top;
    int win_width;
    int win_height;

    t_rgba blended_q[$];
    t_row  dir_rows[$];
    int    mismatches;
    int    quiet_cycles;
    bit    src_gaps;
    bit    sink_gaps;
    int    sink_hold;

    alpha_over_compositor_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_x    (cur_pix.x),
        .i_pixel_y    (cur_pix.y),
        .i_base_red   (cur_pix.base_red),
        .i_base_green (cur_pix.base_green),
        .i_base_blue  (cur_pix.base_blue),
        .i_base_alpha (cur_pix.base_alpha),
        .i_over_red   (cur_pix.over_red),
        .i_over_green (cur_pix.over_green),
        .i_over_blue  (cur_pix.over_blue),
        .i_over_alpha (cur_pix.over_alpha),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic void set_window(input aoc_pkg::t_reg_idx idx, input logic [31:0] data);
        int v;
        v = int'(data[12:0]);
        case (idx)
            aoc_pkg::REG_LEFT:   win_left   = data[12] ? v - 8192 : v;
            aoc_pkg::REG_TOP:    win_top    = data[12] ? v - 8192 : v;
            aoc_pkg::REG_WIDTH:
                win_width  = (v > int'(aoc_pkg::MAX_WIDTH_DEF)) ?
                             int'(aoc_pkg::MAX_WIDTH_DEF) : v;
            aoc_pkg::REG_HEIGHT:
                win_height = (v > int'(aoc_pkg::MAX_HEIGHT_DEF)) ?
                             int'(aoc_pkg::MAX_HEIGHT_DEF) : v;
            default: ;
        endcase
    endfunction

    function automatic t_rgba blend_over(input t_pix p);
        int          px;
        int          py;
        int unsigned sa;
        int unsigned da;
        int unsigned a;
        int unsigned n;
        int unsigned c;
        int unsigned src [3];
        int unsigned dst [3];
        int unsigned chan [3];
        t_rgba       r;
        px = int'(p.x);
        py = int'(p.y);
        src[0] = p.over_red;
        src[1] = p.over_green;
        src[2] = p.over_blue;
        dst[0] = p.base_red;
        dst[1] = p.base_green;
        dst[2] = p.base_blue;
        sa = p.over_alpha;
        da = p.base_alpha;
        if (!(px >= win_left && px < win_left + win_width &&
              py >= win_top && py < win_top + win_height)) begin
            r = {p.base_red, p.base_green, p.base_blue, p.base_alpha};
            return r;
        end
        a = sa * 255 + da * (255 - sa);
        if (a == 0) begin
            r = '0;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            n = src[i] * sa * 255 + dst[i] * da * (255 - sa);
            // round half up
            c = (2 * n + a) / (2 * a);
            chan[i] = (c > 255) ? 255 : c;
        end
        r.red   = chan[0][7:0];
        r.green = chan[1][7:0];
        r.blue  = chan[2][7:0];
        r.alpha = 8'((a + 127) / 255);
        return r;
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                blended_q.insert(blended_q.size(),
                                 pin_typed ? pin_want : blend_over(cur_pix));
            if (o_valid && !i_stall) begin
                if (blended_q.size() == 0) begin
                    $error("composited pixel arrived with no item pending");
                    mismatches++;
                end else begin
                    want = blended_q.pop_front();
                    check_field("out_red",   want.red,   o_out_red);
                    check_field("out_green", want.green, o_out_green);
                    check_field("out_blue",  want.blue,  o_out_blue);
                    check_field("out_alpha", want.alpha, o_out_alpha);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // receiver back-pressure: mostly short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_stall   <= 1'b1;
            sink_hold <= sink_hold - 1;
        end else if (sink_gaps && $urandom_range(0, 99) < 20) begin
            i_stall   <= 1'b1;
            sink_hold <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 60))
                                                      : int'($urandom_range(0, 2));
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        if (!src_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_pos();
        int v;
        case ($urandom_range(0, 5))
            0:       v = -4096;
            1:       v = 4095;
            2:       v = 0;
            3:       v = int'($urandom_range(0, 32)) - 16;
            default: v = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return 32'(v) & 32'h1FFF;
    endfunction

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd4096;
            2:       return $urandom_range(4097, 8191);
            3:       return 32'd1;
            4:       return $urandom_range(1, 64);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // aim at the window edges and interior, with some uniform spread
    function automatic logic [aoc_pkg::COORD_W-1:0] pick_coord(input int lo, input int span);
        int v;
        case ($urandom_range(0, 3))
            0:       v = lo + int'($urandom_range(0, 4)) - 2;
            1:       v = lo + span + int'($urandom_range(0, 4)) - 2;
            2:       v = (span > 0) ? lo + int'($urandom_range(0, span - 1)) : lo;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[aoc_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [aoc_pkg::CH_W-1:0] pick_chan();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic t_pix rand_pixel();
        t_pix p;
        p.x          = pick_coord(win_left, win_width);
        p.y          = pick_coord(win_top, win_height);
        p.base_red   = pick_chan();
        p.base_green = pick_chan();
        p.base_blue  = pick_chan();
        p.base_alpha = pick_chan();
        p.over_red   = pick_chan();
        p.over_green = pick_chan();
        p.over_blue  = pick_chan();
        p.over_alpha = pick_chan();
        return p;
    endfunction

    function automatic void add_cfg(input aoc_pkg::t_reg_idx idx, input logic [31:0] value);
        t_row r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = value;
        r.pix     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // colors packed as 32'hRRGGBBAA
    function automatic void add_pix(input int x, input int y, input logic [31:0] base_rgba,
                                    input logic [31:0] over_rgba, input bit typed = 1'b0,
                                    input logic [31:0] want_rgba = '0);
        t_row r;
        r.kind    = ROW_PIX;
        r.reg_idx = aoc_pkg::REG_LEFT;
        r.value   = '0;
        r.pix.x   = x[aoc_pkg::COORD_W-1:0];
        r.pix.y   = y[aoc_pkg::COORD_W-1:0];
        {r.pix.base_red, r.pix.base_green, r.pix.base_blue, r.pix.base_alpha} = base_rgba;
        {r.pix.over_red, r.pix.over_green, r.pix.over_blue, r.pix.over_alpha} = over_rgba;
        r.typed   = typed;
        r.want    = t_rgba'(want_rgba);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // all tasks below start and end at a falling edge
    task automatic send_pixel(input t_pix p, input bit typed, input t_rgba want, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_pix   <= p;
        pin_typed <= typed;
        pin_want  <= want;
        i_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (blended_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(input aoc_pkg::t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        set_window(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------- main sequence ----------------

    initial begin
        t_pix p;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        cur_pix      = '0;
        pin_typed    = 1'b0;
        pin_want     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        sink_hold    = 0;
        win_left     = 0;
        win_top      = 0;
        win_width    = 0;
        win_height   = 0;

        // empty window after reset: everything passes through
        add_pix(0, 0, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000);
        add_pix(4095, 4095, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF);
        add_pix(1234, 321, 32'h0C22384E, 32'h112233FF, 1'b1, 32'h0C22384E);
        // oversized window covers the whole frame
        add_cfg(aoc_pkg::REG_LEFT, 32'h0);
        add_cfg(aoc_pkg::REG_TOP, 32'h0);
        add_cfg(aoc_pkg::REG_WIDTH, 32'h1FFF);
        add_cfg(aoc_pkg::REG_HEIGHT, 32'h1000);
        add_pix(0, 0, 32'hC86432FF, 32'h010203FF, 1'b1, 32'h010203FF);
        add_pix(4095, 4095, 32'h09080700, 32'hAABBCC00, 1'b1, 32'h00000000);
        add_pix(7, 9, 32'h0A141EFF, 32'hFFFFFF00, 1'b1, 32'h0A141EFF);
        add_pix(100, 200, 32'h05060780, 32'hF0F0F000, 1'b1, 32'h05060780);
        add_pix(4095, 0, 32'h12345600, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
        add_pix(1, 2, 32'h102030FF, 32'hE0D0C080);
        add_pix(3, 4, 32'hFF00FF01, 32'h00FF0001);
        add_pix(5, 6, 32'h80808001, 32'hFFFFFFFE);
        add_pix(8, 8, 32'hFFFFFFFE, 32'h00000001);
        // negative origin, window first entirely above the frame, then over its corner
        add_cfg(aoc_pkg::REG_LEFT, 32'h1FFF);
        add_cfg(aoc_pkg::REG_TOP, 32'h1000);
        add_cfg(aoc_pkg::REG_WIDTH, 32'd2);
        add_cfg(aoc_pkg::REG_HEIGHT, 32'd4096);
        add_pix(0, 4095, 32'h11223344, 32'h556677FF);
        add_cfg(aoc_pkg::REG_TOP, 32'h1FFF);
        add_pix(0, 0, 32'h11223344, 32'h55667788);
        add_pix(1, 0, 32'h11223344, 32'h55667788);
        add_pix(0, 1, 32'h11223344, 32'h55667788);
        // window at the far corner
        add_cfg(aoc_pkg::REG_LEFT, 32'h0FFF);
        add_cfg(aoc_pkg::REG_TOP, 32'h0FFF);
        add_cfg(aoc_pkg::REG_WIDTH, 32'd4096);
        add_cfg(aoc_pkg::REG_HEIGHT, 32'd1);
        add_pix(4095, 4095, 32'h20406080, 32'hA0C0E040);
        add_pix(4094, 4095, 32'h20406080, 32'hA0C0E040);
        add_pix(4095, 4094, 32'h20406080, 32'hA0C0E040);
        // zero width or zero height empties the window
        add_cfg(aoc_pkg::REG_WIDTH, 32'd0);
        add_pix(4095, 4095, 32'h9988776A, 32'h123456FF, 1'b1, 32'h9988776A);
        add_cfg(aoc_pkg::REG_WIDTH, 32'd1);
        add_cfg(aoc_pkg::REG_HEIGHT, 32'd0);
        add_pix(4095, 4095, 32'h9988776A, 32'h123456FF, 1'b1, 32'h9988776A);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_pipe();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want, pick_gap());
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipe();
            if (ph == 0) begin
                apb_write(aoc_pkg::REG_LEFT, 32'h0);
                apb_write(aoc_pkg::REG_TOP, 32'h0);
                apb_write(aoc_pkg::REG_WIDTH, 32'd4096);
                apb_write(aoc_pkg::REG_HEIGHT, 32'd4096);
            end else begin
                apb_write(aoc_pkg::REG_LEFT, pick_pos());
                apb_write(aoc_pkg::REG_TOP, pick_pos());
                apb_write(aoc_pkg::REG_WIDTH, pick_dim());
                apb_write(aoc_pkg::REG_HEIGHT, pick_dim());
            end
            src_gaps  = ph[0];
            sink_gaps = ph[1];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender until the pipe runs dry
                if (k == PHASE_ITEMS / 2 && ph % 3 == 1) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                    while (blended_q.size() != 0)
                        @(negedge i_clk);
                end
                p = rand_pixel();
                send_pixel(p, 1'b0, '0, pick_gap());
            end
        end

        drain_pipe();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
